// ===== design/multichannel_current_window_qualifier_macros.svh =====
// assertion macros for the current window qualifier checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef MULTICHANNEL_CURRENT_WINDOW_QUALIFIER_MACROS_SVH
`define MULTICHANNEL_CURRENT_WINDOW_QUALIFIER_MACROS_SVH

// same-cycle implication
`define MCWQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mcwq assertion failed");

// next-cycle implication
`define MCWQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mcwq assertion failed");

`endif

// ===== design/mcwq_pkg.sv =====
// shared types and constants of the current window qualifier
// used by the controller, the datapath, the top level and the checker
package mcwq_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CODE_W       = 4;
    localparam int CUR_W        = 16;
    localparam int CNT_W        = 2;
    localparam int COUNT_W      = 5;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MAX      = 3'd4;

    localparam logic [CODE_W-1:0] CODE_TESTING   = 4'd0;
    localparam logic [CODE_W-1:0] CODE_PASS      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_BASE      = 4'd2;
    localparam logic [CODE_W-1:0] CODE_UNCHANGED = 4'd10;

    localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

    // s_tdata layout
    localparam int S_CH_LSB         = 0;
    localparam int S_LEVEL_BIT      = 4;
    localparam int S_REVERSE_BIT    = 5;
    localparam int S_UNDER_TEST_BIT = 6;
    localparam int S_CURRENT_LSB    = 7;
    localparam int S_DATA_W         = 24;
    localparam int S_USER_W         = 2;

    // m_tdata layout
    localparam int M_CH_LSB          = 0;
    localparam int M_CODE_LSB        = 4;
    localparam int M_DECIDED_BIT     = 8;
    localparam int M_ALL_DECIDED_BIT = 9;
    localparam int M_WRITE_BACK_BIT  = 10;
    localparam int M_DATA_W          = 16;

    typedef struct packed {
        logic do_begin;
        logic do_load;
        logic do_sample;
        logic do_finish;
        logic emit_sample;
        logic emit_walk;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic n_zero;
        logic walk_last;
    } ctrl_status_t;

endpackage

// ===== design/mcwq_controller.sv =====
// sequencer of the current window qualifier: accepts requests, times sample results, steps the finish walk
// depends on mcwq_pkg
module mcwq_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mcwq_pkg::S_USER_W-1:0]  s_tuser,
    input  mcwq_pkg::ctrl_status_t         ctrl_status,
    output mcwq_pkg::ctrl_cmd_t            ctrl_cmd
);
    import mcwq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE_OUT,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   accept;
    cmd_t   cmd;

    assign s_tready = s_tready_reg;
    assign accept   = s_tvalid && s_tready_reg;
    assign cmd      = cmd_t'(s_tuser);

    always_comb begin
        ctrl_cmd             = '0;
        ctrl_cmd.do_begin    = accept && (cmd == CMD_BEGIN);
        ctrl_cmd.do_load     = accept && (cmd == CMD_LOAD);
        ctrl_cmd.do_sample   = accept && (cmd == CMD_SAMPLE);
        ctrl_cmd.do_finish   = accept && (cmd == CMD_FINISH);
        ctrl_cmd.emit_sample = (state_reg == ST_SAMPLE_OUT) && ctrl_status.out_free;
        ctrl_cmd.emit_walk   = (state_reg == ST_WALK) && ctrl_status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_SAMPLE: state_next = ST_SAMPLE_OUT;
                        CMD_FINISH: state_next = ctrl_status.n_zero ? ST_IDLE : ST_WALK;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SAMPLE_OUT: begin
                if (ctrl_cmd.emit_sample) state_next = ST_IDLE;
            end
            ST_WALK: begin
                if (ctrl_cmd.emit_walk && ctrl_status.walk_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        s_tready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

endmodule

// ===== design/mcwq_datapath.sv =====
// datapath of the current window qualifier: settings, per-channel verdicts and
// counters, window compare, result register; depends on mcwq_pkg
module mcwq_datapath #(
    parameter int CHANNELS      = 16,
    parameter int CONFIRM_COUNT = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mcwq_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            cfg_valid,
    input  logic [mcwq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcwq_pkg::CFG_W-1:0]      cfg_data,
    input  mcwq_pkg::ctrl_cmd_t             ctrl_cmd,
    output mcwq_pkg::ctrl_status_t          ctrl_status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcwq_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import mcwq_pkg::*;

    localparam int DEPTH = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CONFIRM = CNT_W'(CONFIRM_COUNT);

    // settings
    logic [COUNT_W-1:0] cfg_count_reg, cfg_count_next;
    logic [CUR_W-1:0]   low_min_reg, low_min_next;
    logic [CUR_W-1:0]   low_max_reg, low_max_next;
    logic [CUR_W-1:0]   high_min_reg, high_min_next;
    logic [CUR_W-1:0]   high_max_reg, high_max_next;

    // test state
    logic [CODE_W-1:0] verdict_reg [DEPTH];
    logic [CODE_W-1:0] verdict_next [DEPTH];
    logic [CNT_W-1:0]  ok_reg [DEPTH];
    logic [CNT_W-1:0]  ok_next [DEPTH];
    logic [CNT_W-1:0]  less_reg [DEPTH];
    logic [CNT_W-1:0]  less_next [DEPTH];
    logic              level_reg, level_next;
    logic              reverse_reg, reverse_next;

    // sample result and walk position
    logic [CH_W-1:0]   samp_ch_reg, samp_ch_next;
    logic              samp_ok_reg, samp_ok_next;
    logic              samp_dec_reg, samp_dec_next;
    logic [IDX_W-1:0]  walk_idx_reg, walk_idx_next;

    // result register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [CH_W-1:0]   out_ch_reg, out_ch_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_dec_reg, out_dec_next;
    logic              out_alld_reg, out_alld_next;
    logic              out_wb_reg, out_wb_next;
    logic              out_last_reg, out_last_next;

    // request fields
    logic [CH_W-1:0]   in_ch;
    logic              in_level, in_reverse, in_under_test;
    logic [CUR_W-1:0]  in_current;
    logic [IDX_W-1:0]  in_idx;
    logic              in_ch_ok;

    logic [COUNT_W-1:0] used_n;
    logic [CODE_W-1:0]  base;
    logic [CUR_W-1:0]   win_lo, win_hi;
    logic               is_more, is_less, sample_live, confirm;
    logic [CNT_W-1:0]   ok_cur, less_cur, ok_new, less_new;
    logic [CODE_W-1:0]  sample_code;
    logic [DEPTH-1:0]   active;
    logic               all_done;
    logic [CODE_W-1:0]  walk_code, walk_final;
    logic               walk_testing, walk_last, out_free;
    logic [IDX_W-1:0]   samp_idx;

    assign in_ch         = s_tdata[S_CH_LSB +: CH_W];
    assign in_level      = s_tdata[S_LEVEL_BIT];
    assign in_reverse    = s_tdata[S_REVERSE_BIT];
    assign in_under_test = s_tdata[S_UNDER_TEST_BIT];
    assign in_current    = s_tdata[S_CURRENT_LSB +: CUR_W];
    assign in_idx        = in_ch[IDX_W-1:0];

    assign used_n   = (cfg_count_reg > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : cfg_count_reg;
    assign in_ch_ok = ({1'b0, in_ch} < used_n);
    assign base     = CODE_BASE + {1'b0, level_reg, reverse_reg, 1'b0};
    assign win_lo   = level_reg ? high_min_reg : low_min_reg;
    assign win_hi   = level_reg ? high_max_reg : low_max_reg;

    // window compare, more checked first
    assign ok_cur      = ok_reg[in_idx];
    assign less_cur    = less_reg[in_idx];
    assign is_more     = (in_current > win_hi);
    assign is_less     = !is_more && (in_current < win_lo);
    assign sample_live = in_ch_ok && (verdict_reg[in_idx] == CODE_TESTING);

    always_comb begin
        if (is_more) begin
            ok_new      = '0;
            less_new    = '0;
            sample_code = base;
        end else if (is_less) begin
            ok_new      = ok_cur;
            less_new    = (less_cur == COUNT_MAX) ? less_cur : less_cur + 2'd1;
            sample_code = base + 4'd1;
        end else begin
            ok_new      = (ok_cur == COUNT_MAX) ? ok_cur : ok_cur + 2'd1;
            less_new    = less_cur;
            sample_code = CODE_PASS;
        end
        confirm = (ok_new >= CONFIRM) || (less_new >= CONFIRM);
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            active[i] = (verdict_reg[i] == CODE_TESTING) && (COUNT_W'(i) < used_n);
        end
    end
    assign all_done = ~|active;

    assign walk_code    = verdict_reg[walk_idx_reg];
    assign walk_testing = (walk_code == CODE_TESTING);
    assign walk_final   = walk_testing ? base : walk_code;
    assign walk_last    = ((COUNT_W'(walk_idx_reg) + 5'd1) == used_n);
    assign samp_idx     = samp_ch_reg[IDX_W-1:0];
    assign out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        ctrl_status           = '0;
        ctrl_status.out_free  = out_free;
        ctrl_status.n_zero    = (used_n == '0);
        ctrl_status.walk_last = walk_last;
    end

    // settings writes
    always_comb begin
        cfg_count_next = cfg_count_reg;
        low_min_next   = low_min_reg;
        low_max_next   = low_max_reg;
        high_min_next  = high_min_reg;
        high_max_next  = high_max_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: cfg_count_next = cfg_data[COUNT_W-1:0];
                CFG_LOW_MIN:       low_min_next   = cfg_data;
                CFG_LOW_MAX:       low_max_next   = cfg_data;
                CFG_HIGH_MIN:      high_min_next  = cfg_data;
                CFG_HIGH_MAX:      high_max_next  = cfg_data;
                default:           cfg_count_next = cfg_count_reg;
            endcase
        end
    end

    // verdicts, counters and phase
    always_comb begin
        verdict_next = verdict_reg;
        ok_next      = ok_reg;
        less_next    = less_reg;
        level_next   = level_reg;
        reverse_next = reverse_reg;
        if (ctrl_cmd.do_begin) begin
            level_next   = in_level;
            reverse_next = in_reverse;
            for (int i = 0; i < DEPTH; i++) begin
                verdict_next[i] = CODE_UNCHANGED;
                ok_next[i]      = '0;
                less_next[i]    = '0;
            end
        end else if (ctrl_cmd.do_load && in_ch_ok) begin
            verdict_next[in_idx] = in_under_test ? CODE_TESTING : CODE_UNCHANGED;
            ok_next[in_idx]      = '0;
            less_next[in_idx]    = '0;
        end else if (ctrl_cmd.do_sample && sample_live) begin
            ok_next[in_idx]   = ok_new;
            less_next[in_idx] = less_new;
            if (confirm) verdict_next[in_idx] = sample_code;
        end else if (ctrl_cmd.emit_walk && walk_testing) begin
            verdict_next[walk_idx_reg] = base;
        end
    end

    always_comb begin
        samp_ch_next  = samp_ch_reg;
        samp_ok_next  = samp_ok_reg;
        samp_dec_next = samp_dec_reg;
        walk_idx_next = walk_idx_reg;
        if (ctrl_cmd.do_sample) begin
            samp_ch_next  = in_ch;
            samp_ok_next  = in_ch_ok;
            samp_dec_next = sample_live && confirm;
        end
        if (ctrl_cmd.do_finish) begin
            walk_idx_next = '0;
        end else if (ctrl_cmd.emit_walk) begin
            walk_idx_next = walk_idx_reg + IDX_W'(1);
        end
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_ch_next   = out_ch_reg;
        out_code_next = out_code_reg;
        out_dec_next  = out_dec_reg;
        out_alld_next = out_alld_reg;
        out_wb_next   = out_wb_reg;
        out_last_next = out_last_reg;
        if (ctrl_cmd.emit_sample) begin
            m_tvalid_next = 1'b1;
            out_ch_next   = samp_ch_reg;
            out_code_next = samp_ok_reg ? verdict_reg[samp_idx] : CODE_UNCHANGED;
            out_dec_next  = samp_dec_reg;
            out_alld_next = all_done;
            out_wb_next   = 1'b0;
            out_last_next = 1'b0;
        end else if (ctrl_cmd.emit_walk) begin
            m_tvalid_next = 1'b1;
            out_ch_next   = CH_W'(walk_idx_reg);
            out_code_next = walk_final;
            out_dec_next  = walk_testing;
            out_alld_next = 1'b1;
            out_wb_next   = (walk_final != CODE_PASS) && (walk_final != CODE_UNCHANGED);
            out_last_next = walk_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= 5'd10;
            low_min_reg   <= '0;
            low_max_reg   <= '1;
            high_min_reg  <= '0;
            high_max_reg  <= '1;
            for (int i = 0; i < DEPTH; i++) begin
                verdict_reg[i] <= CODE_UNCHANGED;
                ok_reg[i]      <= '0;
                less_reg[i]    <= '0;
            end
            level_reg     <= 1'b0;
            reverse_reg   <= 1'b0;
            walk_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cfg_count_reg <= cfg_count_next;
            low_min_reg   <= low_min_next;
            low_max_reg   <= low_max_next;
            high_min_reg  <= high_min_next;
            high_max_reg  <= high_max_next;
            verdict_reg   <= verdict_next;
            ok_reg        <= ok_next;
            less_reg      <= less_next;
            level_reg     <= level_next;
            reverse_reg   <= reverse_next;
            walk_idx_reg  <= walk_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_ch_reg  <= samp_ch_next;
        samp_ok_reg  <= samp_ok_next;
        samp_dec_reg <= samp_dec_next;
        out_ch_reg   <= out_ch_next;
        out_code_reg <= out_code_next;
        out_dec_reg  <= out_dec_next;
        out_alld_reg <= out_alld_next;
        out_wb_reg   <= out_wb_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        m_tdata                             = '0;
        m_tdata[M_CH_LSB +: CH_W]           = out_ch_reg;
        m_tdata[M_CODE_LSB +: CODE_W]       = out_code_reg;
        m_tdata[M_DECIDED_BIT]              = out_dec_reg;
        m_tdata[M_ALL_DECIDED_BIT]          = out_alld_reg;
        m_tdata[M_WRITE_BACK_BIT]           = out_wb_reg;
    end

endmodule

// ===== design/multichannel_current_window_qualifier.sv =====
// begin and load requests keep s_tready high; a sample drops s_tready, its result is held
// in the sample registers and moves to the result register when the output is free; a
// finish walks the channels in use through the result register, one result per cycle.
// output stalls hold the walk. synchronous active-low reset restores settings,
// marks every channel unchanged and clears all counters at once
module multichannel_current_window_qualifier #(
    parameter int CHANNELS      = 16,
    parameter int CONFIRM_COUNT = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel, level, reverse, under_test, current
    input  logic [mcwq_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic [mcwq_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_channel, code, decided, all_decided, write_back
    output logic [mcwq_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcwq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcwq_pkg::CFG_W-1:0]      cfg_data
);
    import mcwq_pkg::*;

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;

    assign cfg_ready = 1'b1;

    mcwq_controller u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .ctrl_status (ctrl_status),
        .ctrl_cmd    (ctrl_cmd)
    );

    mcwq_datapath #(
        .CHANNELS      (CHANNELS),
        .CONFIRM_COUNT (CONFIRM_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl_cmd    (ctrl_cmd),
        .ctrl_status (ctrl_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== design/mcwq_checker.sv =====
// port-level checks for the current window qualifier, bound to the top level
// depends on mcwq_pkg and multichannel_current_window_qualifier_macros.svh
`include "multichannel_current_window_qualifier_macros.svh"

module mcwq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mcwq_pkg::S_USER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mcwq_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);
    import mcwq_pkg::*;

    `MCWQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `MCWQ_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && (s_tuser == CMD_SAMPLE), !s_tready)
    `MCWQ_ASSERT_NOW(a_last_all_decided, m_tvalid && m_tlast, m_tdata[M_ALL_DECIDED_BIT])
    `MCWQ_ASSERT_NOW(a_wb_all_decided, m_tvalid && m_tdata[M_WRITE_BACK_BIT], m_tdata[M_ALL_DECIDED_BIT])
    `MCWQ_ASSERT_NOW(a_forced_wb, m_tvalid && m_tlast && m_tdata[M_DECIDED_BIT], m_tdata[M_WRITE_BACK_BIT])

endmodule

bind multichannel_current_window_qualifier mcwq_checker u_mcwq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
